@@ rtl/slot_allocator_linked_list_assert.svh @@
// Assertion macros shared by the slot allocator RTL.
// Needs nothing else; included by the files that carry checks.
`ifndef SLOT_ALLOCATOR_LINKED_LIST_ASSERT_SVH
`define SLOT_ALLOCATOR_LINKED_LIST_ASSERT_SVH

// Condition holds at every edge outside reset.
`define SLA_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("slot allocator check failed");

// Consequent holds in the same cycle as the antecedent.
`define SLA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot allocator check failed");

// Consequent holds in the cycle after the antecedent.
`define SLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot allocator check failed");

`endif

@@ rtl/sla_pkg.sv @@
// Shared types and constants of the slot allocator.
// No dependencies; compiled before every other file.
package sla_pkg;

   // Pool size used when the top level is not overridden
   localparam int SLOTS_DEF  = 128;
   // Fixed field widths of the channels
   localparam int SLOT_W     = 7;
   localparam int LINK_OUT_W = 8;
   localparam int COUNT_W    = 15;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   // The protected slot allocated by init
   localparam int FIRST_SLOT = 0;

   typedef enum logic [1:0] {
      ACT_INIT   = 2'd0,
      ACT_ALLOC  = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      STS_ALLOC   = 3'd0,
      STS_SPARE   = 3'd1,
      STS_FATAL   = 3'd2,
      STS_REMOVED = 3'd3,
      STS_REFUSED = 3'd4,
      STS_DONE    = 3'd5
   } status_type;

   typedef struct packed {
      action_type          action;
      logic                use_spare;
      logic [SLOT_W-1:0]   slot;
   } req_payload_type;

   typedef struct packed {
      status_type            status;
      logic [LINK_OUT_W-1:0] slot_out;
      logic [LINK_OUT_W-1:0] next_slot;
      logic [LINK_OUT_W-1:0] prev_slot;
      logic [COUNT_W-1:0]    count;
   } rsp_payload_type;

   // Engine status seen by the channel logic
   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

endpackage

@@ rtl/sla_chan_if.sv @@
// Valid/ready channel interfaces for request and response items.
// Depends on sla_pkg for the field types.
interface sla_req_if;
   import sla_pkg::*;

   logic                valid;
   logic                ready;
   action_type          action;
   logic                use_spare;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, action, use_spare, slot, input ready);
   modport sink   (input valid, action, use_spare, slot, output ready);
endinterface

interface sla_rsp_if;
   import sla_pkg::*;

   logic                  valid;
   logic                  ready;
   status_type            status;
   logic [LINK_OUT_W-1:0] slot_out;
   logic [LINK_OUT_W-1:0] next_slot;
   logic [LINK_OUT_W-1:0] prev_slot;
   logic [COUNT_W-1:0]    count;

   modport source (output valid, status, slot_out, next_slot, prev_slot, count,
                   input ready);
   modport sink   (input valid, status, slot_out, next_slot, prev_slot, count,
                   output ready);
endinterface

@@ rtl/sla_link_ram.sv @@
// One link memory: single write port, single read port, registered read.
// Depends on sla_pkg for default sizes.
module sla_link_ram #(
   parameter int DEPTH = sla_pkg::SLOTS_DEF,
   parameter int WIDTH = $clog2(sla_pkg::SLOTS_DEF + 1)
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] link_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         link_ff[waddr] <= wdata;
      end
      rdata_ff <= link_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/sla_engine.sv @@
// Sequencer of the allocator: walks, allocates, unlinks and reads slots
// through the forward and back link memories. Depends on sla_pkg,
// sla_link_ram and the assertion macro header.
`include "slot_allocator_linked_list_assert.svh"

module sla_engine #(
   parameter int SLOTS = sla_pkg::SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  sla_pkg::req_payload_type cmd,
   input  logic                     take,
   output sla_pkg::eng_stat_type    stat,
   output sla_pkg::rsp_payload_type result
);
   import sla_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS + 1);
   localparam logic [LW-1:0]         NONE     = LW'(SLOTS);
   localparam logic [LINK_OUT_W-1:0] NONE_OUT = LINK_OUT_W'(SLOTS);
   localparam logic [SW-1:0]         FIRST    = SW'(FIRST_SLOT);
   localparam logic [SW-1:0]         LAST     = SW'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_WALK,
      S_IDLE,
      S_ALLOC,
      S_UNLINK,
      S_PUSH,
      S_READ,
      S_DONE
   } state_type;

   state_type        state_ff,     state_in;
   logic             silent_ff,    silent_in;
   logic [SW-1:0]    walk_ff,      walk_in;
   logic [SW-1:0]    slot_ff,      slot_in;
   logic [LW-1:0]    free_head_ff, free_head_in;
   logic [LW-1:0]    tail_ff,      tail_in;
   logic [COUNT_W-1:0] count_ff,   count_in;
   rsp_payload_type  res_ff,       res_in;

   logic          fwd_we,    bk_we;
   logic [SW-1:0] fwd_waddr, bk_waddr;
   logic [LW-1:0] fwd_wdata, bk_wdata;
   logic [SW-1:0] fwd_raddr, bk_raddr;
   logic [LW-1:0] fwd_rdata, bk_rdata;

   logic          slot_ok;
   logic [SW-1:0] cmd_idx;

   function automatic rsp_payload_type make_res(
      input status_type            sts,
      input logic [LINK_OUT_W-1:0] sout,
      input logic [LINK_OUT_W-1:0] nxt,
      input logic [LINK_OUT_W-1:0] prv
   );
      rsp_payload_type r;
      r.status    = sts;
      r.slot_out  = sout;
      r.next_slot = nxt;
      r.prev_slot = prv;
      r.count     = '0;
      return r;
   endfunction

   sla_link_ram #(.DEPTH(SLOTS), .WIDTH(LW)) u_fwd_ram (
      .clock (clock),
      .we    (fwd_we),
      .waddr (fwd_waddr),
      .wdata (fwd_wdata),
      .raddr (fwd_raddr),
      .rdata (fwd_rdata)
   );

   sla_link_ram #(.DEPTH(SLOTS), .WIDTH(LW)) u_bk_ram (
      .clock (clock),
      .we    (bk_we),
      .waddr (bk_waddr),
      .wdata (bk_wdata),
      .raddr (bk_raddr),
      .rdata (bk_rdata)
   );

   assign slot_ok = int'(cmd.slot) < SLOTS;
   assign cmd_idx = SW'(cmd.slot);

   // next-state and link memory control
   always_comb begin
      state_in     = state_ff;
      silent_in    = silent_ff;
      walk_in      = walk_ff;
      slot_in      = slot_ff;
      free_head_in = free_head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      fwd_we       = 1'b0;
      fwd_waddr    = slot_ff;
      fwd_wdata    = NONE;
      bk_we        = 1'b0;
      bk_waddr     = slot_ff;
      bk_wdata     = NONE;
      fwd_raddr    = cmd_idx;
      bk_raddr     = cmd_idx;

      case (state_ff)
         // rebuild the pool one slot a cycle, slot 0 ends up allocated
         S_WALK: begin
            fwd_we    = 1'b1;
            fwd_waddr = walk_ff;
            fwd_wdata = NONE;
            bk_we     = 1'b1;
            bk_waddr  = walk_ff;
            if (walk_ff == FIRST || walk_ff == LAST) begin
               bk_wdata = NONE;
            end else begin
               bk_wdata = LW'(walk_ff) + LW'(1);
            end
            walk_in = walk_ff + SW'(1);
            if (walk_ff == LAST) begin
               free_head_in = LW'(1);
               tail_in      = LW'(FIRST);
               count_in     = COUNT_W'(1);
               silent_in    = 1'b0;
               if (silent_ff) begin
                  state_in = S_IDLE;
               end else begin
                  res_in   = make_res(STS_DONE, LINK_OUT_W'(FIRST), NONE_OUT, NONE_OUT);
                  state_in = S_DONE;
               end
            end
         end

         // decode a new item and start its memory reads
         S_IDLE: begin
            if (start) begin
               case (cmd.action)
                  ACT_INIT: begin
                     walk_in  = '0;
                     state_in = S_WALK;
                  end
                  ACT_ALLOC: begin
                     if (free_head_ff == NONE) begin
                        res_in   = make_res(cmd.use_spare ? STS_SPARE : STS_FATAL,
                                            NONE_OUT, NONE_OUT, NONE_OUT);
                        state_in = S_DONE;
                     end else begin
                        bk_raddr  = free_head_ff[SW-1:0];
                        fwd_we    = 1'b1;
                        fwd_waddr = free_head_ff[SW-1:0];
                        fwd_wdata = NONE;
                        slot_in   = free_head_ff[SW-1:0];
                        state_in  = S_ALLOC;
                     end
                  end
                  ACT_REMOVE: begin
                     if (!slot_ok || cmd_idx == FIRST) begin
                        res_in   = make_res(STS_REFUSED, NONE_OUT, NONE_OUT, NONE_OUT);
                        state_in = S_DONE;
                     end else begin
                        slot_in  = cmd_idx;
                        state_in = S_UNLINK;
                     end
                  end
                  ACT_READ: begin
                     if (slot_ok) begin
                        state_in = S_READ;
                     end else begin
                        res_in   = make_res(STS_DONE, NONE_OUT, NONE_OUT, NONE_OUT);
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // append the old free head at the tail
         S_ALLOC: begin
            free_head_in = bk_rdata;
            bk_we        = 1'b1;
            bk_waddr     = slot_ff;
            bk_wdata     = tail_ff;
            if (tail_ff != NONE) begin
               fwd_we    = 1'b1;
               fwd_waddr = tail_ff[SW-1:0];
               fwd_wdata = LW'(slot_ff);
            end
            tail_in = LW'(slot_ff);
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
            res_in   = make_res(STS_ALLOC, LINK_OUT_W'(slot_ff), NONE_OUT, NONE_OUT);
            state_in = S_DONE;
         end

         // bridge the neighbors around the removed slot
         S_UNLINK: begin
            if (LW'(slot_ff) == tail_ff) begin
               tail_in = bk_rdata;
            end else if (fwd_rdata != NONE) begin
               bk_we    = 1'b1;
               bk_waddr = fwd_rdata[SW-1:0];
               bk_wdata = bk_rdata;
            end
            if (bk_rdata != NONE) begin
               fwd_we    = 1'b1;
               fwd_waddr = bk_rdata[SW-1:0];
               fwd_wdata = fwd_rdata;
            end
            state_in = S_PUSH;
         end

         // push the removed slot onto the free chain
         S_PUSH: begin
            bk_we        = 1'b1;
            bk_waddr     = slot_ff;
            bk_wdata     = free_head_ff;
            free_head_in = LW'(slot_ff);
            res_in       = make_res(STS_REMOVED, NONE_OUT, NONE_OUT, NONE_OUT);
            state_in     = S_DONE;
         end

         S_READ: begin
            res_in   = make_res(STS_DONE, NONE_OUT, LINK_OUT_W'(fwd_rdata),
                                LINK_OUT_W'(bk_rdata));
            state_in = S_DONE;
         end

         // hold the result until the output register takes it
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WALK;
         silent_ff    <= 1'b1;
         walk_ff      <= '0;
         free_head_ff <= LW'(1);
         tail_ff      <= LW'(FIRST);
         count_ff     <= COUNT_W'(1);
      end else begin
         state_ff     <= state_in;
         silent_ff    <= silent_in;
         walk_ff      <= walk_in;
         free_head_ff <= free_head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
      slot_ff <= slot_in;
      res_ff  <= res_in;
   end

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_DONE);

   always_comb begin
      result       = res_ff;
      result.count = count_ff;
   end

   `SLA_ASSERT_NEXT(a_start_leaves_idle, clock, reset, start, !stat.idle)
   `SLA_ASSERT_ALWAYS(a_free_head_range, clock, reset, free_head_ff <= NONE)
   `SLA_ASSERT_ALWAYS(a_tail_range, clock, reset, tail_ff <= NONE)
   `SLA_ASSERT_ALWAYS(a_count_nonzero, clock, reset, count_ff != '0)
   `SLA_ASSERT_NEXT(a_first_refused, clock, reset,
      start && cmd.action == ACT_REMOVE && cmd.slot == SLOT_W'(FIRST_SLOT),
      stat.done && res_ff.status == STS_REFUSED)
endmodule

@@ rtl/slot_allocator_linked_list.sv @@
// Slot allocator with a free chain and a doubly linked active list. One item
// is worked at a time; ready is high only while the sequencer is idle, and the
// result sits in an output register so the next item can be taken while it
// waits. A refused remove, a full-pool allocate or an out-of-range read is
// answered from the decode state; allocate passes through the allocate state,
// read through the read state, remove through the unlink and push states. The
// sequence is set by the two link memories, each with one write and one
// registered read port, and by init walking every slot once. After reset the
// same walk over all SLOTS slots (128 by default) runs with ready low and no result item.
// Depends on sla_pkg, sla_chan_if and sla_engine.
module slot_allocator_linked_list #(
   parameter int SLOTS = sla_pkg::SLOTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sla_req_if.sink   req_chan,
   sla_rsp_if.source rsp_chan
);
   import sla_pkg::*;

   eng_stat_type    stat;
   rsp_payload_type result;
   req_payload_type cmd;
   logic            start;
   logic            take;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   // request side
   assign req_chan.ready = stat.idle;
   assign start          = req_chan.valid && stat.idle;
   assign cmd.action     = req_chan.action;
   assign cmd.use_spare  = req_chan.use_spare;
   assign cmd.slot       = req_chan.slot;

   sla_engine #(.SLOTS(SLOTS)) u_engine (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cmd    (cmd),
      .take   (take),
      .stat   (stat),
      .result (result)
   );

   // output register loads when empty or being drained
   assign take = stat.done && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_data_ff.status;
   assign rsp_chan.slot_out  = rsp_data_ff.slot_out;
   assign rsp_chan.next_slot = rsp_data_ff.next_slot;
   assign rsp_chan.prev_slot = rsp_data_ff.prev_slot;
   assign rsp_chan.count     = rsp_data_ff.count;
endmodule

@@ tb/tb.sv @@
// Testbench for the slot allocator: drives random and directed items on the
// request channel and checks every response item against a software pool model.
// Depends on sla_pkg, the channel interfaces and slot_allocator_linked_list.
`timescale 1ns / 1ps

module tb;
   import sla_pkg::*;

   localparam int POOL = SLOTS_DEF;
   localparam logic [LINK_OUT_W-1:0] NO_SLOT = LINK_OUT_W'(POOL);
   localparam int RANDOM_ITEMS = 680;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int LONG_HOLD_AT = 150;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int REPORT_LIMIT = 10;

   // Pool model plus the queue of responses still owed by the block
   class slot_pool_scoreboard;
      logic [LINK_OUT_W-1:0] fwd_link [POOL];
      logic [LINK_OUT_W-1:0] back_link [POOL];
      logic [LINK_OUT_W-1:0] free_head;
      logic [LINK_OUT_W-1:0] tail_slot;
      logic [LINK_OUT_W-1:0] first_slot;
      logic [COUNT_W-1:0]    alloc_count;
      rsp_payload_type       pending_results[$];
      int                    mismatches;

      function new();
         mismatches = 0;
         rebuild_pool();
      endfunction

      // Pop the free head and append it at the tail of the active list
      function logic [LINK_OUT_W-1:0] take_free_slot();
         logic [LINK_OUT_W-1:0] n;
         n = free_head;
         if (n >= NO_SLOT) return NO_SLOT;
         free_head = back_link[n];
         fwd_link[n] = NO_SLOT;
         if (tail_slot < NO_SLOT) fwd_link[tail_slot] = n;
         back_link[n] = tail_slot;
         tail_slot = n;
         if (alloc_count != COUNT_MAX) alloc_count = alloc_count + 1'b1;
         return n;
      endfunction

      // Chain every slot as free, then allocate the protected first slot
      function void rebuild_pool();
         for (int i = 0; i < POOL; i++) begin
            back_link[i] = (i + 1 < POOL) ? LINK_OUT_W'(i + 1) : NO_SLOT;
            fwd_link[i] = NO_SLOT;
         end
         free_head = '0;
         tail_slot = NO_SLOT;
         alloc_count = '0;
         first_slot = take_free_slot();
      endfunction

      function rsp_payload_type note_request(req_payload_type item);
         rsp_payload_type       exp;
         logic [LINK_OUT_W-1:0] n, f, b, s;
         exp.status = STS_DONE;
         exp.slot_out = NO_SLOT;
         exp.next_slot = NO_SLOT;
         exp.prev_slot = NO_SLOT;
         s = LINK_OUT_W'(item.slot);
         case (item.action)
            ACT_INIT: begin
               rebuild_pool();
               exp.slot_out = first_slot;
            end
            ACT_ALLOC: begin
               n = take_free_slot();
               if (n < NO_SLOT) begin
                  exp.status = STS_ALLOC;
                  exp.slot_out = n;
               end else begin
                  exp.status = item.use_spare ? STS_SPARE : STS_FATAL;
               end
            end
            ACT_REMOVE: begin
               if (s >= NO_SLOT || s == first_slot) begin
                  exp.status = STS_REFUSED;
               end else begin
                  // unlink; the removed slot keeps its forward link
                  f = fwd_link[s];
                  b = back_link[s];
                  if (s == tail_slot) tail_slot = b;
                  else if (f < NO_SLOT) back_link[f] = b;
                  if (b < NO_SLOT) fwd_link[b] = f;
                  back_link[s] = free_head;
                  free_head = s;
                  exp.status = STS_REMOVED;
               end
            end
            default: begin
               if (s < NO_SLOT) begin
                  exp.next_slot = fwd_link[s];
                  exp.prev_slot = back_link[s];
               end
            end
         endcase
         exp.count = alloc_count;
         pending_results.push_back(exp);
         return exp;
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type exp;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: response item with nothing outstanding: status %0d slot %0d",
                        $realtime, got.status, got.slot_out);
            return;
         end
         exp = pending_results.pop_front();
         if (got.status !== exp.status || got.slot_out !== exp.slot_out ||
             got.next_slot !== exp.next_slot || got.prev_slot !== exp.prev_slot ||
             got.count !== exp.count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: mismatch, expected status %0d slot %0d next %0d prev %0d count %0d",
                        $realtime, exp.status, exp.slot_out, exp.next_slot, exp.prev_slot,
                        exp.count);
               $display("%0t:           actual status %0d slot %0d next %0d prev %0d count %0d",
                        $realtime, got.status, got.slot_out, got.next_slot, got.prev_slot,
                        got.count);
            end
         end
      endfunction

      function int pending_count();
         return pending_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic rsp_take = 1'b0;
   logic rsp_free_run = 1'b0;
   bit   sender_gaps_on = 1'b1;
   int   items_sent = 0;
   int   cycle_count = 0;
   int   results_taken = 0;
   int   hold_left = 0;
   int   stall_left = 0;
   int   calm_left = 0;
   bit   long_hold_done = 1'b0;
   logic [SLOT_W-1:0] live_slots[$];
   slot_pool_scoreboard sb;

   sla_req_if req_if ();
   sla_rsp_if rsp_if ();

   assign rsp_if.ready = rsp_take;

   slot_allocator_linked_list #(.SLOTS(POOL)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle length: mostly short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 92) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [SLOT_W-1:0] any_slot();
      return SLOT_W'($urandom_range(0, POOL - 1));
   endfunction

   // Aim removes at slots believed active; the tail gets extra weight
   function automatic logic [SLOT_W-1:0] pick_live_slot();
      if (live_slots.size() == 0) return SLOT_W'($urandom_range(1, POOL - 1));
      if ($urandom_range(0, 3) == 0) return live_slots[live_slots.size() - 1];
      return live_slots[$urandom_range(0, live_slots.size() - 1)];
   endfunction

   // Random pause on the request side, with junk fields while valid is low
   task automatic sender_pause();
      int gap;
      if (sender_gaps_on && $urandom_range(0, 99) < 35) begin
         gap = pick_gap();
         req_if.valid <= 1'b0;
         req_if.action <= action_type'($urandom_range(0, 3));
         req_if.use_spare <= 1'($urandom_range(0, 1));
         req_if.slot <= any_slot();
         repeat (gap) @(posedge clock);
      end
   endtask

   // Offer one item, wait for acceptance, log the expected response
   task automatic send_item(input action_type act, input logic spare,
                            input logic [SLOT_W-1:0] target);
      req_payload_type item;
      rsp_payload_type exp;
      item.action = act;
      item.use_spare = spare;
      item.slot = target;
      req_if.valid <= 1'b1;
      req_if.action <= act;
      req_if.use_spare <= spare;
      req_if.slot <= target;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      exp = sb.note_request(item);
      items_sent++;
      case (act)
         ACT_INIT: live_slots.delete();
         ACT_ALLOC: begin
            if (exp.status == STS_ALLOC) live_slots.push_back(exp.slot_out[SLOT_W-1:0]);
         end
         ACT_REMOVE: begin
            if (exp.status == STS_REMOVED)
               for (int i = live_slots.size() - 1; i >= 0; i--)
                  if (live_slots[i] == target) live_slots.delete(i);
         end
         default: ;
      endcase
      sender_pause();
   endtask

   // Hold the request side until every owed response has arrived
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Response side: random stalls, calm stretches, one long hold-off
   always @(posedge clock) begin : result_sink
      int roll;
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) results_taken <= results_taken + 1;
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_take <= 1'b0;
      end else if (!long_hold_done && results_taken >= LONG_HOLD_AT) begin
         long_hold_done <= 1'b1;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_take <= 1'b0;
      end else if (rsp_free_run || calm_left > 0) begin
         if (calm_left > 0) calm_left <= calm_left - 1;
         rsp_take <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_take <= 1'b0;
      end else begin
         rsp_take <= 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 20) stall_left <= pick_gap();
         else if (roll < 23) calm_left <= $urandom_range(40, 120);
      end
   end

   // Compare each accepted response item with the oldest expectation
   always @(posedge clock) begin : result_monitor
      rsp_payload_type got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.status = rsp_if.status;
         got.slot_out = rsp_if.slot_out;
         got.next_slot = rsp_if.next_slot;
         got.prev_slot = rsp_if.prev_slot;
         got.count = rsp_if.count;
         sb.check_result(got);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int kind, burst, roll, random_end;
      bit drained_mid;
      sb = new();
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.action <= ACT_INIT;
      req_if.use_spare <= 1'b0;
      req_if.slot <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every action, first-slot refusal, inactive removes
      send_item(ACT_INIT, 1'b0, 7'd0);
      send_item(ACT_READ, 1'b0, 7'd0);
      send_item(ACT_READ, 1'b0, 7'd1);
      send_item(ACT_READ, 1'b1, 7'd127);
      send_item(ACT_REMOVE, 1'b0, 7'd0);
      send_item(ACT_ALLOC, 1'b0, 7'd0);
      send_item(ACT_ALLOC, 1'b1, 7'd127);
      send_item(ACT_ALLOC, 1'b0, 7'd0);
      send_item(ACT_READ, 1'b0, 7'd2);
      send_item(ACT_REMOVE, 1'b0, 7'd2);
      send_item(ACT_READ, 1'b0, 7'd2);
      send_item(ACT_REMOVE, 1'b1, 7'd3);
      send_item(ACT_ALLOC, 1'b0, 7'd0);
      send_item(ACT_REMOVE, 1'b0, 7'd1);
      send_item(ACT_REMOVE, 1'b0, 7'd40);
      send_item(ACT_READ, 1'b0, 7'd40);
      send_item(ACT_REMOVE, 1'b1, 7'd127);
      send_item(ACT_READ, 1'b1, 7'd127);
      send_item(ACT_ALLOC, 1'b1, 7'd85);
      send_item(ACT_READ, 1'b0, 7'd0);
      send_item(ACT_INIT, 1'b1, 7'd127);
      send_item(ACT_ALLOC, 1'b0, 7'd0);
      send_item(ACT_READ, 1'b1, 7'd85);
      wait_for_results();

      // Random episodes: mixed traffic, pool fills, remove runs, re-inits
      random_end = items_sent + RANDOM_ITEMS;
      drained_mid = 1'b0;
      while (items_sent < random_end) begin
         kind = $urandom_range(0, 9);
         sender_gaps_on = ($urandom_range(0, 4) != 0);
         if (!drained_mid && items_sent >= random_end - RANDOM_ITEMS / 2) begin
            drained_mid = 1'b1;
            wait_for_results();
         end
         if (kind == 0) begin
            send_item(ACT_INIT, 1'($urandom_range(0, 1)), any_slot());
         end else if (kind == 1) begin
            // allocate until full (bounded: a broken free chain may never empty)
            burst = 0;
            while (sb.free_head < NO_SLOT && burst < POOL + 8) begin
               send_item(ACT_ALLOC, 1'($urandom_range(0, 1)), any_slot());
               burst++;
            end
            repeat ($urandom_range(1, 4))
               send_item(ACT_ALLOC, 1'($urandom_range(0, 1)), any_slot());
         end else if (kind <= 3) begin
            repeat ($urandom_range(5, 30))
               send_item(ACT_REMOVE, 1'($urandom_range(0, 1)), pick_live_slot());
         end else begin
            repeat ($urandom_range(15, 50)) begin
               roll = $urandom_range(0, 99);
               if (roll < 45)
                  send_item(ACT_ALLOC, 1'($urandom_range(0, 1)), any_slot());
               else if (roll < 72)
                  send_item(ACT_REMOVE, 1'($urandom_range(0, 1)), pick_live_slot());
               else if (roll < 88)
                  send_item(ACT_READ, 1'($urandom_range(0, 1)),
                            $urandom_range(0, 1) ? pick_live_slot() : any_slot());
               else if (roll < 97)
                  send_item(ACT_REMOVE, 1'($urandom_range(0, 1)),
                            ($urandom_range(0, 3) == 0) ? 7'd0 : any_slot());
               else
                  send_item(ACT_INIT, 1'($urandom_range(0, 1)), any_slot());
            end
         end
      end
      wait_for_results();

      // Full pool: fill it, refuse extras, then recycle slots at full speed
      rsp_free_run <= 1'b1;
      sender_gaps_on = 1'b0;
      send_item(ACT_INIT, 1'b0, any_slot());
      repeat (POOL - 1) send_item(ACT_ALLOC, 1'($urandom_range(0, 1)), any_slot());
      send_item(ACT_ALLOC, 1'b0, any_slot());
      send_item(ACT_ALLOC, 1'b1, any_slot());
      send_item(ACT_REMOVE, 1'b1, 7'd0);
      repeat (8) begin
         send_item(ACT_REMOVE, 1'($urandom_range(0, 1)), pick_live_slot());
         send_item(ACT_ALLOC, 1'($urandom_range(0, 1)), any_slot());
      end
      send_item(ACT_ALLOC, 1'b0, any_slot());
      send_item(ACT_ALLOC, 1'b1, any_slot());
      send_item(ACT_READ, 1'b0, pick_live_slot());
      send_item(ACT_INIT, 1'b1, any_slot());
      wait_for_results();
      rsp_free_run <= 1'b0;

      // Let any stray response item show up before the verdict
      repeat (POOL + 16) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_count() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
